/* sv/ais_pkg.sv */
// ----------------------------------------------------------------------------
// ais_pkg
// Shared constants, codes and types for the packed-list command engine.
// ----------------------------------------------------------------------------
package ais_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 5;
    localparam int FIDX_BITS  = 4;
    localparam int STAT_BITS  = 2;
    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int CMP_BITS   = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } command_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK       = 2'd0,
        STAT_BADPOS   = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // what a cell loads at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    new_word;
    } cell_ctl_t;

endpackage

/* sv/ais_if.sv */
// ----------------------------------------------------------------------------
// ais_if
// Valid/ready channels for commands and results of the list engine.
// ----------------------------------------------------------------------------
interface ais_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            command;
    logic [ais_pkg::POS_BITS-1:0]          position;
    logic signed [ais_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface ais_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [ais_pkg::STAT_BITS-1:0]         status;
    logic [ais_pkg::FIDX_BITS-1:0]         found_index;
    logic signed [ais_pkg::VALUE_BITS-1:0] read_value;
    logic [ais_pkg::CNT_BITS-1:0]          entry_count;

    modport source (output valid, status, found_index, read_value, entry_count,
                    input ready);
    modport sink   (input valid, status, found_index, read_value, entry_count,
                    output ready);
endinterface

/* sv/ais_cell.sv */
// ----------------------------------------------------------------------------
// ais_cell
// One list slot: holds a word, shifts to or from its neighbours, matches a key.
// ----------------------------------------------------------------------------
module ais_cell (
    input  logic                clk,
    input  ais_pkg::cell_ctl_t  ctl,
    input  ais_pkg::word_t      left_word,
    input  ais_pkg::word_t      right_word,
    input  ais_pkg::word_t      key,
    output ais_pkg::word_t      word,
    output logic                match
);

    ais_pkg::word_t word_reg;
    ais_pkg::word_t word_next;

    always_comb
    begin
        case (ctl.op)
            ais_pkg::CELL_HOLD:       word_next = word_reg;
            ais_pkg::CELL_LOAD:       word_next = ctl.new_word;
            ais_pkg::CELL_FROM_LEFT:  word_next = left_word;
            ais_pkg::CELL_FROM_RIGHT: word_next = right_word;
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == key);

endmodule

/* sv/array_insert_delete_search.sv */
// the result is registered when the execute state ends; the sequencer runs one command
//   at a time, so no new command is taken until the last one completes, and the whole
//   cell row matches and shifts in the cycle in which execute ends
// a waiting result holds the engine in execute until the sink takes it
// reset clears the entry count, the sequencer and the result valid;
//   slot contents are undefined until written
// ----------------------------------------------------------------------------
// array_insert_delete_search
// Packed list of signed words in a row of cells: insert, delete, search, read.
// ----------------------------------------------------------------------------
module array_insert_delete_search (
    input  logic       clk,
    input  logic       rst_n,
    ais_cmd_if.sink    cmd,
    ais_res_if.source  res
);

    localparam int D  = ais_pkg::DEPTH;
    localparam int CB = ais_pkg::CMP_BITS;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    fsm_t                          state_reg, state_next;
    logic [ais_pkg::CNT_BITS-1:0]  count_reg, count_next;
    ais_pkg::command_t             cmd_reg;
    logic [ais_pkg::POS_BITS-1:0]  pos_reg;
    ais_pkg::word_t                key_reg;

    logic                          out_valid_reg, out_valid_next;
    ais_pkg::status_t              status_reg, status_next;
    logic [ais_pkg::FIDX_BITS-1:0] fidx_reg, fidx_next;
    logic [ais_pkg::VALUE_BITS-1:0] rdval_reg, rdval_next;

    ais_pkg::cell_ctl_t            ctl [D];
    ais_pkg::word_t                words [D];
    logic [D-1:0]                  match;

    logic                          exec_go;
    logic [CB-1:0]                 pos_w, cnt_w, pos_m1, hit_w;
    logic [D-1:0]                  hits;
    logic                          any_hit;
    logic [ais_pkg::IDX_BITS-1:0]  rd_idx;

    // cell row
    for (genvar g = 0; g < D; g++)
    begin : g_cell
        ais_cell u_cell (
            .clk        (clk),
            .ctl        (ctl[g]),
            .left_word  ((g == 0) ? words[g] : words[(g == 0) ? 0 : g-1]),
            .right_word ((g == D-1) ? words[g] : words[(g == D-1) ? g : g+1]),
            .key        (key_reg),
            .word       (words[g]),
            .match      (match[g])
        );
    end

    assign cmd.ready = (state_reg == FSM_IDLE);
    assign exec_go   = (state_reg == FSM_EXEC) && (!out_valid_reg || res.ready);

    assign pos_w  = CB'(pos_reg);
    assign cnt_w  = CB'(count_reg);
    assign pos_m1 = pos_w - CB'(1);
    assign rd_idx = ais_pkg::IDX_BITS'(pos_m1);

    // first live match
    always_comb
    begin
        hit_w = '0;
        for (int i = 0; i < D; i++)
        begin
            hits[i] = match[i] && (CB'(i) < cnt_w);
        end
        any_hit = |hits;
        for (int i = D-1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_w = CB'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        fidx_next      = fidx_reg;
        rdval_next     = rdval_reg;
        for (int i = 0; i < D; i++)
        begin
            ctl[i].op       = ais_pkg::CELL_HOLD;
            ctl[i].new_word = key_reg;
        end

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = FSM_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ais_pkg::STAT_OK;
                    fidx_next      = '0;
                    rdval_next     = '0;
                    case (cmd_reg)
                        ais_pkg::CMD_INSERT:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w + CB'(1))
                            begin
                                status_next = ais_pkg::STAT_BADPOS;
                            end
                            else if (cnt_w >= CB'(D))
                            begin
                                status_next = ais_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + ais_pkg::CNT_BITS'(1);
                                for (int i = 0; i < D; i++)
                                begin
                                    if (CB'(i) == pos_m1)
                                    begin
                                        ctl[i].op = ais_pkg::CELL_LOAD;
                                    end
                                    else if (CB'(i) > pos_m1 && CB'(i) <= cnt_w)
                                    begin
                                        ctl[i].op = ais_pkg::CELL_FROM_LEFT;
                                    end
                                end
                            end
                        end
                        ais_pkg::CMD_DELETE, ais_pkg::CMD_SEARCH:
                        begin
                            if (!any_hit)
                            begin
                                status_next = ais_pkg::STAT_NOTFOUND;
                            end
                            else
                            begin
                                fidx_next = ais_pkg::FIDX_BITS'(hit_w);
                                if (cmd_reg == ais_pkg::CMD_DELETE)
                                begin
                                    count_next = count_reg - ais_pkg::CNT_BITS'(1);
                                    for (int i = 0; i < D; i++)
                                    begin
                                        if (CB'(i) >= hit_w && CB'(i) + CB'(1) < cnt_w)
                                        begin
                                            ctl[i].op = ais_pkg::CELL_FROM_RIGHT;
                                        end
                                    end
                                end
                            end
                        end
                        ais_pkg::CMD_READ:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                status_next = ais_pkg::STAT_BADPOS;
                            end
                            else
                            begin
                                rdval_next = ais_pkg::VALUE_BITS'(words[rd_idx]);
                            end
                        end
                        default:
                        begin
                            status_next = ais_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= ais_pkg::command_t'(cmd.command);
            pos_reg <= cmd.position;
            key_reg <= ais_pkg::WORD_BITS'($unsigned(cmd.value));
        end
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        rdval_reg  <= rdval_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = status_reg;
    assign res.found_index = fidx_reg;
    assign res.read_value  = $signed(rdval_reg);
    assign res.entry_count = count_reg;

endmodule

/* bench/array_insert_delete_search_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_insert_delete_search_tb
// Drives insert, delete, search and read commands into the packed list engine
// and checks every result against a shadow copy of the list kept here.
// ----------------------------------------------------------------------------
module array_insert_delete_search_tb;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        ais_pkg::status_t                      status;
        logic [ais_pkg::FIDX_BITS-1:0]         found_index;
        ais_pkg::word_t                        read_value;
        logic [ais_pkg::CNT_BITS-1:0]          entry_count;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ais_cmd_if cmd_ch();
    ais_res_if res_ch();

    array_insert_delete_search uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // shadow of the list held by the engine
    ais_pkg::word_t shadow_list [ais_pkg::DEPTH];
    int             held;
    bit             growing;
    list_result_t   pending_results [$];
    int             errors = 0;
    int             quiet_cycles = 0;
    int             src_idle_pct;
    int             sink_stall_pct;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // works out the result of one command and updates the shadow list
    function automatic list_result_t apply_command(ais_pkg::command_t op,
                                                   logic [ais_pkg::POS_BITS-1:0] pos,
                                                   ais_pkg::word_t word);
        list_result_t r;
        int           p;
        int           hit;
        int           i;
        p             = pos;
        hit           = -1;
        r.status      = ais_pkg::STAT_OK;
        r.found_index = '0;
        r.read_value  = '0;
        case (op)
            ais_pkg::CMD_INSERT:
            begin
                if (p < 1 || p > held + 1)
                    r.status = ais_pkg::STAT_BADPOS;
                else if (held >= ais_pkg::DEPTH)
                    r.status = ais_pkg::STAT_FULL;
                else
                begin
                    for (i = held; i > p - 1; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p-1] = word;
                    held++;
                end
            end
            ais_pkg::CMD_DELETE, ais_pkg::CMD_SEARCH:
            begin
                for (i = 0; i < held && hit < 0; i++)
                    if (shadow_list[i] == word)
                        hit = i;
                if (hit < 0)
                    r.status = ais_pkg::STAT_NOTFOUND;
                else
                begin
                    r.found_index = hit[ais_pkg::FIDX_BITS-1:0];
                    if (op == ais_pkg::CMD_DELETE)
                    begin
                        for (i = hit; i + 1 < held; i++)
                            shadow_list[i] = shadow_list[i+1];
                        held--;
                    end
                end
            end
            default:
            begin
                if (p < 1 || p > held)
                    r.status = ais_pkg::STAT_BADPOS;
                else
                    r.read_value = shadow_list[p-1];
            end
        endcase
        r.entry_count = held[ais_pkg::CNT_BITS-1:0];
        return r;
    endfunction

    // one command transfer; returns at the accepting edge
    task automatic send_command(ais_pkg::command_t op, logic [ais_pkg::POS_BITS-1:0] pos,
                                logic signed [ais_pkg::VALUE_BITS-1:0] word);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= op;
        cmd_ch.position <= pos;
        cmd_ch.value    <= word;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_results.push_back(apply_command(op, pos, word));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // list values most of the time, so that searches and deletes hit
    function automatic logic signed [ais_pkg::VALUE_BITS-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (held > 0 && sel < 55)
            return shadow_list[$urandom_range(0, held - 1)];
        else if (sel < 75)
            return 32'($urandom_range(0, 7)) - 32'd4;
        else if (sel < 82)
        begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    // ready toggles on the falling edge
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d count %0d",
                         $time, res_ch.status, res_ch.entry_count);
                errors++;
            end
            else
            begin
                list_result_t want;
                want = pending_results.pop_front();
                if (res_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, res_ch.status);
                    errors++;
                end
                if (res_ch.found_index !== want.found_index)
                begin
                    $display("%0t: found_index expected %0d actual %0d",
                             $time, want.found_index, res_ch.found_index);
                    errors++;
                end
                if (res_ch.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, res_ch.read_value);
                    errors++;
                end
                if (res_ch.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, res_ch.entry_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic test_empty_list();
        send_command(ais_pkg::CMD_READ,   5'd1, 32'sd0);
        send_command(ais_pkg::CMD_SEARCH, 5'd0, 32'sd0);
        send_command(ais_pkg::CMD_DELETE, 5'd9, 32'h8000_0000);
        send_command(ais_pkg::CMD_INSERT, 5'd0, 32'sd11);
        send_command(ais_pkg::CMD_INSERT, 5'd2, 32'sd11);
    endtask

    // inserts at the front, the back and the middle until the list is full
    task automatic test_insert_and_fill();
        int i;
        int p;
        send_command(ais_pkg::CMD_INSERT, 5'd1, 32'h8000_0000);
        send_command(ais_pkg::CMD_INSERT, 5'd2, 32'h7fff_ffff);
        send_command(ais_pkg::CMD_INSERT, 5'd1, 32'sd5);
        send_command(ais_pkg::CMD_INSERT, 5'd3, 32'sd5);
        for (i = 0; i < ais_pkg::DEPTH - 4; i++)
        begin
            p = (i % 3 == 0) ? 1 : (i % 3 == 1) ? held + 1 : $urandom_range(1, held + 1);
            send_command(ais_pkg::CMD_INSERT, p[ais_pkg::POS_BITS-1:0], 32'(i * 1000 + 7));
        end
    endtask

    task automatic test_full_list();
        // the position is checked before fullness
        send_command(ais_pkg::CMD_INSERT, 5'(ais_pkg::DEPTH + 1), 32'sd1);
        send_command(ais_pkg::CMD_INSERT, 5'(ais_pkg::DEPTH + 2), 32'sd1);
        send_command(ais_pkg::CMD_READ,   5'(ais_pkg::DEPTH),     32'sd0);
        send_command(ais_pkg::CMD_READ,   5'(ais_pkg::DEPTH + 1), 32'sd0);
        send_command(ais_pkg::CMD_READ,   5'd0,                   32'sd0);
    endtask

    task automatic test_search_and_delete();
        send_command(ais_pkg::CMD_SEARCH, 5'd0,  32'sd5);
        send_command(ais_pkg::CMD_SEARCH, 5'd31, 32'sd12345);
        send_command(ais_pkg::CMD_DELETE, 5'd0,  32'sd5);
        send_command(ais_pkg::CMD_DELETE, 5'd0,  32'sd12345);
        send_command(ais_pkg::CMD_SEARCH, 5'd0,  32'sd5);
    endtask

    task automatic test_random_traffic(int n, int src_pct, int sink_pct);
        ais_pkg::command_t                     op;
        logic [ais_pkg::POS_BITS-1:0]          pos;
        logic signed [ais_pkg::VALUE_BITS-1:0] word;
        int                                    r;
        int                                    ins_pct;
        int                                    del_pct;
        int                                    k;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (k = 0; k < n; k++)
        begin
            // swing the list between empty and full
            if (held == ais_pkg::DEPTH)
                growing = 1'b0;
            else if (held == 0)
                growing = 1'b1;
            ins_pct = growing ? 50 : 15;
            del_pct = growing ? 10 : 45;
            r       = $urandom_range(99);
            word    = pick_value();
            pos     = ais_pkg::POS_BITS'($urandom_range(0, 31));
            if (r < ins_pct)
            begin
                op = ais_pkg::CMD_INSERT;
                if ($urandom_range(99) < 85)
                    pos = ais_pkg::POS_BITS'($urandom_range(1, held + 1));
            end
            else if (r < ins_pct + del_pct)
                op = ais_pkg::CMD_DELETE;
            else if (r < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2)
                op = ais_pkg::CMD_SEARCH;
            else
            begin
                op = ais_pkg::CMD_READ;
                if (held > 0 && $urandom_range(99) < 85)
                    pos = ais_pkg::POS_BITS'($urandom_range(1, held));
            end
            if ($urandom_range(63) == 0)
                wait_for_results();
            send_command(op, pos, word);
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = ais_pkg::CMD_INSERT;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        held            = 0;
        growing         = 1'b1;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_and_fill();
        test_full_list();
        test_search_and_delete();
        wait_for_results();

        test_random_traffic(205, 0, 0);
        test_random_traffic(205, 75, 0);
        test_random_traffic(205, 0, 75);
        test_random_traffic(205, 21, 21);

        repeat (4) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
